>>> hdl/icm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icm_pkg
// shared types and constants of the inpainting confidence map
// ----------------------------------------------------------------------------
package icm_pkg;

   localparam int MAX_WIDTH      = 256;
   localparam int MAX_HEIGHT     = 256;
   localparam int MAX_RADIUS     = 15;
   localparam int CONF_FRAC_BITS = 15;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_MASK   = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UPDATE = 2'd3;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SUM_RD,
      ST_SUM_WAIT,
      ST_DIV,
      ST_WR_RD,
      ST_WR_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic setup;
      logic sum_step;
      logic div_start;
      logic wr_step;
      logic scan_reset;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_patch;
      logic is_update;
      logic empty;
      logic scan_last;
      logic div_done;
   } stat_type;

endpackage
`default_nettype wire

>>> hdl/inpaint_confidence_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inpaint_confidence_map
// hole mask and confidence map with patch confidence query and update
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_cmd req_pixel_x req_pixel_y req_is_hole
// rsp      out  rsp_valid/rsp_stall  rsp_confidence
// csr      in   csr_write            csr_index csr_data
//
// load and mask go from setup straight to the response; query reads the clipped patch
// through the memory port, a read state and a wait state per pixel, then runs the
// one-bit-a-cycle divider; update then walks the patch again to write its holes.
// one transaction at a time; reset is synchronous, memories are not cleared.
// a stalled response holds; the next transaction is taken and waits for it
// before loading its own response.
module inpaint_confidence_map #(
   parameter int MAX_WIDTH      = icm_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT     = icm_pkg::MAX_HEIGHT,
   parameter int MAX_RADIUS     = icm_pkg::MAX_RADIUS,
   parameter int CONF_FRAC_BITS = icm_pkg::CONF_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_pixel_x,
   input  wire logic [7:0]  req_pixel_y,
   input  wire logic        req_is_hole,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_confidence,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);
   icm_pkg::cmd_type  ctl;
   icm_pkg::stat_type stat;

   icm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .ctl(ctl));

   icm_datapath #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_RADIUS(MAX_RADIUS), .CONF_FRAC_BITS(CONF_FRAC_BITS)
   ) u_dp (
      .clock(clock), .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_cmd(req_cmd), .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .req_is_hole(req_is_hole), .reset(reset), .ctl(ctl), .stat(stat),
      .rsp_confidence(rsp_confidence));
endmodule
`default_nettype wire

>>> hdl/icm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icm_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module icm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

>>> hdl/icm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icm_ctrl
// sequencer for load, mask, query and update transactions
// ----------------------------------------------------------------------------
module icm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire icm_pkg::stat_type stat,
   output icm_pkg::cmd_type       ctl
);
   icm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         icm_pkg::ST_IDLE:     if (req_valid) state_in = icm_pkg::ST_SETUP;
         icm_pkg::ST_SETUP: begin
            if (!stat.is_patch || stat.empty) state_in = icm_pkg::ST_RESP;
            else state_in = icm_pkg::ST_SUM_RD;
         end
         icm_pkg::ST_SUM_RD:   state_in = icm_pkg::ST_SUM_WAIT;
         icm_pkg::ST_SUM_WAIT: begin
            if (stat.scan_last) state_in = icm_pkg::ST_DIV;
            else state_in = icm_pkg::ST_SUM_RD;
         end
         icm_pkg::ST_DIV: begin
            if (stat.div_done) begin
               if (stat.is_update) state_in = icm_pkg::ST_WR_RD;
               else state_in = icm_pkg::ST_RESP;
            end
         end
         icm_pkg::ST_WR_RD:    state_in = icm_pkg::ST_WR_WAIT;
         icm_pkg::ST_WR_WAIT: begin
            if (stat.scan_last) state_in = icm_pkg::ST_RESP;
            else state_in = icm_pkg::ST_WR_RD;
         end
         icm_pkg::ST_RESP:     if (!rsp_valid_ff || !rsp_stall) state_in = icm_pkg::ST_IDLE;
         default:              state_in = icm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         icm_pkg::ST_IDLE:     ctl.start = req_valid;
         icm_pkg::ST_SETUP:    ctl.setup = 1'b1;
         icm_pkg::ST_SUM_WAIT: begin
            ctl.sum_step   = 1'b1;
            ctl.div_start  = stat.scan_last;
            ctl.scan_reset = stat.scan_last;
         end
         icm_pkg::ST_WR_WAIT:  ctl.wr_step = 1'b1;
         icm_pkg::ST_RESP:     ctl.rsp_load = !rsp_valid_ff || !rsp_stall;
         default:              ctl = '0;
      endcase
   end

   assign req_stall = (state_ff != icm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (ctl.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= icm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> req_stall) else $error("new transaction taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("stalled response dropped");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten");
endmodule
`default_nettype wire

>>> hdl/icm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icm_datapath
// patch scan, memories, divider and response register
// ----------------------------------------------------------------------------
module icm_datapath #(
   parameter int MAX_WIDTH      = icm_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT     = icm_pkg::MAX_HEIGHT,
   parameter int MAX_RADIUS     = icm_pkg::MAX_RADIUS,
   parameter int CONF_FRAC_BITS = icm_pkg::CONF_FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [8:0]        csr_data,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [7:0]        req_pixel_x,
   input  wire logic [7:0]        req_pixel_y,
   input  wire logic              req_is_hole,
   input  wire logic              reset,
   input  wire icm_pkg::cmd_type  ctl,
   output icm_pkg::stat_type      stat,
   output logic [15:0]            rsp_confidence
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW;
   localparam int CW = CONF_FRAC_BITS + 1;
   localparam int PW = 2 * $clog2(2 * MAX_RADIUS + 2);
   localparam int SW = CW + PW;
   localparam int DW = SW + 1;
   localparam int QC = $clog2(DW + 1);
   localparam logic [CW-1:0] ONE = CW'(1) << CONF_FRAC_BITS;

   logic [3:0] radius_ff;
   logic [8:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd4;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_write) begin
         unique case (csr_index)
            icm_pkg::REG_RADIUS: radius_ff <= csr_data[3:0];
            icm_pkg::REG_WIDTH:  width_ff  <= csr_data;
            icm_pkg::REG_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective limits, signed 14 bit
   logic signed [13:0] w_eff, h_eff, r_eff;
   always_comb begin
      w_eff = (width_ff == 9'd0) ? 14'sd1 : 14'(width_ff);
      if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
      h_eff = (height_ff == 9'd0) ? 14'sd1 : 14'(height_ff);
      if (h_eff > 14'(MAX_HEIGHT)) h_eff = 14'(MAX_HEIGHT);
      r_eff = (radius_ff > 4'(MAX_RADIUS)) ? 14'(MAX_RADIUS) : 14'(radius_ff);
   end

   logic [1:0]  cmd_ff;
   logic [7:0]  px_ff, py_ff;
   logic        hole_ff;
   logic signed [13:0] x0_ff, x1_ff, y0_ff, y1_ff, cx_ff, cy_ff;
   logic signed [13:0] x0_in, x1_in, y0_in, y1_in;
   logic        empty_ff;

   always_comb begin
      x0_in = 14'(px_ff) - r_eff;
      x1_in = 14'(px_ff) + r_eff;
      y0_in = 14'(py_ff) - r_eff;
      y1_in = 14'(py_ff) + r_eff;
      if (x0_in < 0) x0_in = '0;
      if (y0_in < 0) y0_in = '0;
      if (x1_in > w_eff - 14'sd1) x1_in = w_eff - 14'sd1;
      if (y1_in > h_eff - 14'sd1) y1_in = h_eff - 14'sd1;
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cmd_ff  <= req_cmd;
         px_ff   <= req_pixel_x;
         py_ff   <= req_pixel_y;
         hole_ff <= req_is_hole;
      end
      if (ctl.setup) begin
         x0_ff     <= x0_in;
         x1_ff     <= x1_in;
         y0_ff     <= y0_in;
         y1_ff     <= y1_in;
         cx_ff     <= x0_in;
         cy_ff     <= y0_in;
         empty_ff  <= (x0_in > x1_in) || (y0_in > y1_in);
      end else if (ctl.sum_step || ctl.wr_step) begin
         if (ctl.scan_reset || (cx_ff == x1_ff && cy_ff == y1_ff)) begin
            cx_ff <= x0_ff;
            cy_ff <= y0_ff;
         end else if (cx_ff == x1_ff) begin
            cx_ff <= x0_ff;
            cy_ff <= cy_ff + 14'sd1;
         end else begin
            cx_ff <= cx_ff + 14'sd1;
         end
      end
   end

   logic pix_write;
   logic pix_inside;
   logic [AW-1:0] addr;
   logic          mask_we, conf_we;
   logic          mask_wd, mask_rd;
   logic [CW-1:0] conf_wd, conf_rd;
   logic [CW-1:0] q_ff;

   assign pix_inside = (14'(px_ff) < w_eff) && (14'(py_ff) < h_eff);
   assign pix_write  = ctl.setup && !cmd_ff[1] && pix_inside;

   always_comb begin
      if (ctl.setup) addr = {YW'(py_ff), XW'(px_ff)};
      else addr = {cy_ff[YW-1:0], cx_ff[XW-1:0]};
      mask_we = pix_write;
      mask_wd = hole_ff;
      conf_we = (pix_write && cmd_ff == icm_pkg::CMD_LOAD) || (ctl.wr_step && mask_rd);
      conf_wd = ctl.wr_step ? q_ff : (hole_ff ? '0 : ONE);
   end

   icm_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_mask (
      .clock(clock), .we(mask_we), .addr(addr), .wdata(mask_wd), .rdata(mask_rd));
   icm_ram #(.WIDTH(CW), .DEPTH(1 << AW)) u_conf (
      .clock(clock), .we(conf_we), .addr(addr), .wdata(conf_wd), .rdata(conf_rd));

   // sum and area
   logic [SW-1:0] sum_ff;
   logic [PW-1:0] area;
   always_comb begin
      area = PW'(x1_ff - x0_ff + 14'sd1) * PW'(y1_ff - y0_ff + 14'sd1);
   end
   always_ff @(posedge clock) begin
      if (ctl.setup) sum_ff <= '0;
      else if (ctl.sum_step && !mask_rd) sum_ff <= sum_ff + SW'(conf_rd);
   end

   // restoring divider, one bit a cycle
   logic [DW-1:0] num_ff, rem_ff;
   logic [QC-1:0] cnt_ff;
   logic          busy_ff;
   logic [DW-1:0] rem_sh;
   logic [DW-1:0] rem_t;
   always_comb begin
      rem_sh = {rem_ff[DW-2:0], num_ff[DW-1]};
      rem_t  = rem_sh - DW'(area);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctl.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= QC'(DW);
         rem_ff  <= '0;
         num_ff  <= DW'(sum_ff + SW'(conf_rd & {CW{!mask_rd}})) + DW'(area >> 1);
      end else if (busy_ff) begin
         if (rem_sh >= DW'(area)) begin
            rem_ff <= rem_t;
            num_ff <= {num_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[DW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - QC'(1);
         if (cnt_ff == QC'(1)) busy_ff <= 1'b0;
      end
   end

   logic div_done_ff;
   always_ff @(posedge clock) begin
      if (reset) div_done_ff <= 1'b0;
      else div_done_ff <= busy_ff && cnt_ff == QC'(1);
      if (ctl.setup) begin
         q_ff <= '0;
      end else if (busy_ff && cnt_ff == QC'(1)) begin
         q_ff <= ({num_ff[DW-2:0], (rem_sh >= DW'(area))} > DW'(ONE)) ? ONE
               : CW'({num_ff[DW-2:0], (rem_sh >= DW'(area))});
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_confidence <= (cmd_ff[1] && !empty_ff) ? 16'(q_ff) : 16'd0;
      end
   end

   always_comb begin
      stat.is_patch  = cmd_ff[1];
      stat.is_update = (cmd_ff == icm_pkg::CMD_UPDATE);
      stat.empty     = (x0_in > x1_in) || (y0_in > y1_in);
      stat.scan_last = (cx_ff == x1_ff) && (cy_ff == y1_ff);
      stat.div_done  = div_done_ff;
   end

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.div_start |=> busy_ff) else $error("divider did not start");
   a_no_wr_in_sum: assert property (@(posedge clock) disable iff (reset)
      ctl.sum_step |-> !conf_we) else $error("write during sum scan");
   a_q_range: assert property (@(posedge clock) disable iff (reset)
      div_done_ff |-> q_ff <= ONE) else $error("confidence above one");
endmodule
`default_nettype wire

>>> tb/icm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icm_checker
// watches the request, response and register ports of the confidence map,
// keeps its own mask and confidence store, predicts each patch confidence
// and compares every response with the oldest prediction
// ----------------------------------------------------------------------------
module icm_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_pixel_x,
   input  wire logic [7:0]  req_pixel_y,
   input  wire logic        req_is_hole,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [15:0] rsp_confidence,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data,
   output int               errors,
   output int               pending
);

   localparam int CONF_ONE = 1 << icm_pkg::CONF_FRAC_BITS;
   localparam int PIXELS   = icm_pkg::MAX_WIDTH * icm_pkg::MAX_HEIGHT;

   logic        hole_bit [0:PIXELS-1];
   logic [15:0] conf_val [0:PIXELS-1];
   logic [3:0]  radius_reg;
   logic [8:0]  width_reg;
   logic [8:0]  height_reg;
   logic [15:0] conf_q [$];
   int          err_count;

   function automatic int used_dim(logic [8:0] v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : int'(v);
   endfunction

   // patch confidence of the clipped patch, written into its holes on update
   function automatic logic [15:0] patch_conf(int cx, int cy, bit fill);
      int     w, h, r, x0, x1, y0, y1, a;
      longint sum, area, q;
      w = used_dim(width_reg, icm_pkg::MAX_WIDTH);
      h = used_dim(height_reg, icm_pkg::MAX_HEIGHT);
      r = (radius_reg > icm_pkg::MAX_RADIUS) ? icm_pkg::MAX_RADIUS : int'(radius_reg);
      x0 = (cx - r < 0) ? 0 : cx - r;
      y0 = (cy - r < 0) ? 0 : cy - r;
      x1 = (cx + r > w - 1) ? w - 1 : cx + r;
      y1 = (cy + r > h - 1) ? h - 1 : cy + r;
      if (x0 > x1 || y0 > y1) return 16'd0;
      sum = 0;
      area = longint'(x1 - x0 + 1) * longint'(y1 - y0 + 1);
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++) begin
            a = y * icm_pkg::MAX_WIDTH + x;
            if (!hole_bit[a]) sum += conf_val[a];
         end
      q = (sum + area / 2) / area;
      if (q > CONF_ONE) q = CONF_ONE;
      if (fill)
         for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++) begin
               a = y * icm_pkg::MAX_WIDTH + x;
               if (hole_bit[a]) conf_val[a] = q[15:0];
            end
      return q[15:0];
   endfunction

   always @(posedge clock) begin
      int          a;
      logic [15:0] want;
      if (reset) begin
         radius_reg <= 4'd4;
         width_reg  <= 9'd256;
         height_reg <= 9'd256;
         conf_q.delete();
         err_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               icm_pkg::REG_RADIUS: radius_reg <= csr_data[3:0];
               icm_pkg::REG_WIDTH:  width_reg  <= csr_data;
               icm_pkg::REG_HEIGHT: height_reg <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = 16'd0;
            if (req_cmd == icm_pkg::CMD_LOAD || req_cmd == icm_pkg::CMD_MASK) begin
               if (req_pixel_x < used_dim(width_reg, icm_pkg::MAX_WIDTH) &&
                   req_pixel_y < used_dim(height_reg, icm_pkg::MAX_HEIGHT)) begin
                  a = int'(req_pixel_y) * icm_pkg::MAX_WIDTH + int'(req_pixel_x);
                  hole_bit[a] = req_is_hole;
                  if (req_cmd == icm_pkg::CMD_LOAD)
                     conf_val[a] = req_is_hole ? 16'd0 : 16'(CONF_ONE);
               end
            end else begin
               want = patch_conf(req_pixel_x, req_pixel_y,
                                 req_cmd == icm_pkg::CMD_UPDATE);
            end
            conf_q = {conf_q, want};
         end
         if (rsp_valid && !rsp_stall) begin
            if (conf_q.size() == 0) begin
               $display("%0t: response with none expected, actual %0d", $time, rsp_confidence);
               err_count++;
            end else begin
               want = conf_q.pop_front();
               if (rsp_confidence !== want) begin
                  $display("%0t: confidence mismatch, expected %0d actual %0d",
                           $time, want, rsp_confidence);
                  err_count++;
               end
            end
         end
      end
      errors  <= err_count;
      pending <= conf_q.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the inpainting confidence map: directed corner cases, then
// random loads, mask changes, queries and updates over several image and
// patch settings, with random request gaps and response stalls on the two channels
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] REG_NONE = 2'd3;
   localparam int LIMIT = 12000000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 75;
   localparam int MW = icm_pkg::MAX_WIDTH;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = icm_pkg::CMD_LOAD;
   logic [7:0]  req_pixel_x = '0;
   logic [7:0]  req_pixel_y = '0;
   logic        req_is_hole = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_confidence;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = icm_pkg::REG_RADIUS;
   logic [8:0]  csr_data = '0;
   int          errors, pending;

   bit          loaded [0:icm_pkg::MAX_WIDTH*icm_pkg::MAX_HEIGHT-1];
   int          use_r = 4, use_w = 256, use_h = 256;
   int          cmd_count [4];
   int          cycles = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;

   int phase_r [PHASES] = '{4, 0, 15, 2, 15, 7, 1, 9};
   int phase_w [PHASES] = '{256, 256, 8, 16, 511, 300, 40, 5};
   int phase_h [PHASES] = '{256, 256, 8, 12, 0, 511, 24, 256};

   always #10 clock = ~clock;

   inpaint_confidence_map dut (.*);

   icm_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // response back pressure, with quiet stretches of no stall
   always @(posedge clock) begin
      int n;
      if ($urandom_range(0, 99) == 0) quiet <= ~quiet;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = quiet ? 0 : $urandom_range(0, 19);
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   function automatic int used_dim(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // first never-loaded pixel of the clipped patch, -1 when all are loaded
   function automatic int missing_pixel(int cx, int cy);
      int x0, x1, y0, y1;
      x0 = (cx - use_r < 0) ? 0 : cx - use_r;
      y0 = (cy - use_r < 0) ? 0 : cy - use_r;
      x1 = (cx + use_r > use_w - 1) ? use_w - 1 : cx + use_r;
      y1 = (cy + use_r > use_h - 1) ? use_h - 1 : cy + use_r;
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            if (!loaded[y * MW + x]) return y * MW + x;
      return -1;
   endfunction

   task automatic send(logic [1:0] cmd, int x, int y, bit hole);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if ((cmd == icm_pkg::CMD_LOAD) && x < use_w && y < use_h) loaded[y * MW + x] = 1'b1;
      cmd_count[cmd]++;
      req_cmd     <= cmd;
      req_pixel_x <= x[7:0];
      req_pixel_y <= y[7:0];
      req_is_hole <= hole;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_set(logic [1:0] idx, int value);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[8:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         icm_pkg::REG_RADIUS:
            use_r = (value > icm_pkg::MAX_RADIUS) ? icm_pkg::MAX_RADIUS : value;
         icm_pkg::REG_WIDTH:  use_w = used_dim(value, icm_pkg::MAX_WIDTH);
         icm_pkg::REG_HEIGHT: use_h = used_dim(value, icm_pkg::MAX_HEIGHT);
         default: ;
      endcase
   endtask

   task automatic configure(int r, int w, int h);
      drain();
      csr_set(icm_pkg::REG_RADIUS, r);
      csr_set(icm_pkg::REG_WIDTH, w);
      csr_set(icm_pkg::REG_HEIGHT, h);
   endtask

   task automatic random_item();
      int  pick, x, y, miss;
      bit  hole;
      pick = $urandom_range(0, 99);
      hole = ($urandom_range(0, 3) == 0);
      if (pick < 80) begin
         x = $urandom_range(0, 15);
         y = $urandom_range(0, 15);
      end else begin
         x = $urandom_range(0, 255);
         y = $urandom_range(0, 255);
      end
      if (pick < 30) begin
         send(icm_pkg::CMD_LOAD, x, y, hole);
      end else if (pick < 40) begin
         if (x < use_w && y < use_h && !loaded[y * MW + x])
            send(icm_pkg::CMD_LOAD, x, y, hole);
         else send(icm_pkg::CMD_MASK, x, y, $urandom_range(0, 1));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            x = $urandom_range(240, 255);
            y = $urandom_range(240, 255);
         end
         miss = missing_pixel(x, y);
         if (miss >= 0) send(icm_pkg::CMD_LOAD, miss % MW, miss / MW, hole);
         else send(($urandom_range(0, 1) != 0) ? icm_pkg::CMD_UPDATE : icm_pkg::CMD_QUERY,
                   x, y, $urandom_range(0, 1));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-pixel image
      csr_set(REG_NONE, 511);
      configure(0, 1, 1);
      send(icm_pkg::CMD_LOAD, 0, 0, 1'b0);
      send(icm_pkg::CMD_QUERY, 0, 0, 1'b0);
      send(icm_pkg::CMD_UPDATE, 0, 0, 1'b1);
      send(icm_pkg::CMD_LOAD, 255, 255, 1'b1);
      send(icm_pkg::CMD_MASK, 255, 0, 1'b1);
      send(icm_pkg::CMD_QUERY, 255, 255, 1'b0);
      send(icm_pkg::CMD_UPDATE, 0, 255, 1'b0);
      send(icm_pkg::CMD_MASK, 0, 0, 1'b1);
      send(icm_pkg::CMD_QUERY, 0, 0, 1'b0);
      send(icm_pkg::CMD_UPDATE, 0, 0, 1'b0);
      send(icm_pkg::CMD_LOAD, 0, 0, 1'b1);
      send(icm_pkg::CMD_UPDATE, 0, 0, 1'b0);
      send(icm_pkg::CMD_MASK, 0, 0, 1'b0);
      send(icm_pkg::CMD_QUERY, 0, 0, 1'b1);
      // zero size acts as one, widest radius
      configure(15, 0, 0);
      send(icm_pkg::CMD_QUERY, 0, 0, 1'b0);
      send(icm_pkg::CMD_QUERY, 15, 15, 1'b0);
      send(icm_pkg::CMD_UPDATE, 16, 16, 1'b0);
      send(icm_pkg::CMD_QUERY, 255, 0, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         configure(phase_r[p], phase_w[p], phase_h[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) drain();
            random_item();
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d loads, %0d mask writes, %0d queries, %0d updates",
               cmd_count[icm_pkg::CMD_LOAD], cmd_count[icm_pkg::CMD_MASK],
               cmd_count[icm_pkg::CMD_QUERY], cmd_count[icm_pkg::CMD_UPDATE]);
      $display("over %0d image and patch settings in %0d cycles", PHASES + 2, cycles);
      if (errors == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> inpaint_confidence_map.f
hdl/icm_pkg.sv
hdl/icm_ram.sv
hdl/icm_ctrl.sv
hdl/icm_datapath.sv
hdl/inpaint_confidence_map.sv
tb/icm_checker.sv
tb/tb.sv
